@@ hw/rtl/rhd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_pkg: shared constants and helpers for the half-size downscaler
// Frame limits, counter and line store widths, register indexes and the
// per-channel adder used by the 2x2 box filter.
// ----------------------------------------------------------------------------
package rhd_pkg;

  // frame limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // configuration register width and indexes
  localparam int DIM_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = DIM_W'(480);

  // effective dimension and counter widths
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // line store geometry: one entry per horizontal pixel pair
  localparam int HALF_STORE = MAX_WIDTH / 2;
  localparam int SLOT_W     = $clog2(HALF_STORE);

  // sample and pair sum lanes
  localparam int SAMPLE_W = 8;
  localparam int PIX_W    = 3 * SAMPLE_W;
  localparam int LANE_W   = SAMPLE_W + 1;
  localparam int SUM_W    = 3 * LANE_W;

  // sum of two 8-bit samples, no overflow
  function automatic logic [LANE_W-1:0] pair_add(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b);
    pair_add = {1'b0, a} + {1'b0, b};
  endfunction

endpackage

@@ hw/rtl/rgb_half_downscale_bgr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_half_downscale_bgr_core: 2x2 box filter downscaler, RGB in, BGR out
// Averages each 2x2 block of a raster RGB888 frame into one half-size pixel.
// ----------------------------------------------------------------------------
// Usage
//   in_*   : one source pixel per word, raster order, any idle pattern.
//   out_*  : one half-size BGR pixel per 2x2 block; tlast marks the last
//            pixel of an output row, tuser the last pixel of the frame.
//   cfg_*  : image_width (index 0) and image_height (index 1), written
//            while the block is idle; cfg_ready is always high.
// Pipeline: a result passes through stage 1 and the output register after
//   the word that completes its block (bottom-right pixel) is accepted.
// Throughput: one source pixel per cycle while the output is not stalled;
//   the line store is written through one port and read through the other,
//   and a write never falls in the cycle of a used read, since a slot written
//   on an even row is read for a block a full row later.
// Reset: counters restart at the top-left pixel, registers return to
//   640 x 480; the line store needs no clearing, as every entry is written
//   on an even row before it is read.
// Stall: while out_tvalid is high and out_tready low, the whole pipeline
//   holds and in_tready is low.
// ----------------------------------------------------------------------------
module rgb_half_downscale_bgr_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // source pixels
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rhd_pkg::PIX_W-1:0]      in_tdata,   // in_red, in_green, in_blue
  // half-size pixels
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rhd_pkg::PIX_W-1:0]      out_tdata,  // out_blue, out_green, out_red
  output logic                           out_tlast,  // row_end
  output logic                           out_tuser,  // frame_end
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rhd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rhd_pkg::DIM_W-1:0]      cfg_data
);

  import rhd_pkg::*;

  // configuration registers
  logic [DIM_W-1:0] image_width_r, image_width_nxt;
  logic [DIM_W-1:0] image_height_r, image_height_nxt;

  // position counters and pair holding register
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] pair_hold_r;

  // stage 1: pair sums waiting for the line store read
  logic             s1_valid_r, s1_valid_nxt;
  logic [SUM_W-1:0] s1_sums_r;
  logic             s1_rend_r;
  logic             s1_fend_r;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_data_r;
  logic             out_last_r;
  logic             out_user_r;

  // datapath signals
  logic             adv;
  logic             accept;
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [WID_W-1:0] col_ext;
  logic [HGT_W-1:0] row_ext;
  logic             active;
  logic             pair_done;
  logic             wr_en;
  logic             rd_req;
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0] sums;
  logic             rend;
  logic             fend;
  logic [SUM_W-1:0] top_sums;
  logic [PIX_W-1:0] avg_bgr;

  // the whole pipeline moves when the output register is free or taken
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;
  assign cfg_ready = 1'b1;

  // configuration write decode
  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_nxt  = cfg_data;
        REG_IMAGE_HEIGHT: image_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // clamp dimensions to the supported range
  always_comb begin
    if (image_width_r < DIM_W'(2)) begin
      w_eff = WID_W'(2);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(image_width_r);
    end
    if (image_height_r < DIM_W'(2)) begin
      h_eff = HGT_W'(2);
    end else if (32'(image_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = HGT_W'(image_height_r);
    end
  end

  // position decode for the current source pixel
  assign col_ext   = WID_W'(col_r);
  assign row_ext   = HGT_W'(row_r);
  assign active    = (col_ext < {w_eff[WID_W-1:1], 1'b0}) &&
                     (row_ext < {h_eff[HGT_W-1:1], 1'b0});
  assign pair_done = accept && active && col_r[0];
  assign wr_en     = pair_done && !row_r[0];
  assign rd_req    = pair_done && row_r[0];
  assign slot      = col_r[SLOT_W:1];
  assign rend      = (col_ext >> 1) == ((w_eff >> 1) - WID_W'(1));
  assign fend      = rend && ((row_ext >> 1) == ((h_eff >> 1) - HGT_W'(1)));

  // horizontal pair sums, red in the low lane
  assign sums = {pair_add(pair_hold_r[3*SAMPLE_W-1:2*SAMPLE_W],
                          in_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
                 pair_add(pair_hold_r[2*SAMPLE_W-1:SAMPLE_W],
                          in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
                 pair_add(pair_hold_r[SAMPLE_W-1:0], in_tdata[SAMPLE_W-1:0])};

  // counter stepping, wraps at the end of each row and frame
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_ext + WID_W'(1) >= w_eff) begin
        col_nxt = '0;
        if (row_ext + HGT_W'(1) >= h_eff) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // even-row pair sums line store
  rhd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (HALF_STORE)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (sums),
    .rd_en   (adv),
    .rd_addr (slot),
    .rd_data (top_sums)
  );

  // vertical add and divide by four, packed blue first
  always_comb begin
    logic [LANE_W:0] tot_r;
    logic [LANE_W:0] tot_g;
    logic [LANE_W:0] tot_b;
    tot_r = {1'b0, top_sums[LANE_W-1:0]} + {1'b0, s1_sums_r[LANE_W-1:0]};
    tot_g = {1'b0, top_sums[2*LANE_W-1:LANE_W]} +
            {1'b0, s1_sums_r[2*LANE_W-1:LANE_W]};
    tot_b = {1'b0, top_sums[3*LANE_W-1:2*LANE_W]} +
            {1'b0, s1_sums_r[3*LANE_W-1:2*LANE_W]};
    avg_bgr = {tot_r[LANE_W:2], tot_g[LANE_W:2], tot_b[LANE_W:2]};
  end

  assign s1_valid_nxt  = adv ? rd_req : s1_valid_r;
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers; only a pixel inside the cropped frame is held
  always_ff @(posedge clk) begin
    if (accept && active && !col_r[0]) begin
      pair_hold_r <= in_tdata;
    end
    if (adv) begin
      s1_sums_r  <= sums;
      s1_rend_r  <= rend;
      s1_fend_r  <= fend;
      out_data_r <= avg_bgr;
      out_last_r <= s1_rend_r;
      out_user_r <= s1_fend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // frame end only on the last pixel of a row
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser || out_tlast))
    else $error("frame end without row end");

  // line store is never written in the same cycle as a block read is requested
  assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_req))
    else $error("line store read and write collide");

  // a pending block result reaches the output register when the pipe moves
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r) |=> out_tvalid)
    else $error("block result lost between stages");

  // a stalled output keeps the input side closed and stage 1 in place
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready ##1 $stable(s1_valid_r))
    else $error("pipeline moved during output stall");

endmodule

@@ hw/rtl/rhd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module rhd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ test/half_pixel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_pixel_checker: scoreboard for the 2x2 RGB to BGR downscaler
// Watches the source, result and register channels of the core. It keeps
// its own copy of the frame counters, the held pixel and the even-row pair
// sums, and it queues the half-size pixel each finished 2x2 block should
// produce. Every result word is compared field by field with the oldest
// queued pixel. The top reads the failure count and the number of pixels
// still owed.
// ----------------------------------------------------------------------------
module half_pixel_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [rhd_pkg::PIX_W-1:0]     in_tdata,   // in_red, in_green, in_blue
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [rhd_pkg::PIX_W-1:0]     out_tdata,  // out_blue, out_green, out_red
  input  logic                          out_tlast,  // row_end
  input  logic                          out_tuser,  // frame_end
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rhd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rhd_pkg::DIM_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            pending
);
  import rhd_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] red;
    logic                row_end;
    logic                frame_end;
  } half_pixel_t;

  typedef struct packed {
    logic [LANE_W-1:0] red;
    logic [LANE_W-1:0] green;
    logic [LANE_W-1:0] blue;
  } pair_sum_t;

  // register copies and frame position
  logic [DIM_W-1:0]    width_reg;
  logic [DIM_W-1:0]    height_reg;
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [SAMPLE_W-1:0] held_red;
  logic [SAMPLE_W-1:0] held_green;
  logic [SAMPLE_W-1:0] held_blue;
  pair_sum_t           even_sums [HALF_STORE];

  half_pixel_t expected_pixels [$];
  int          mismatch_count = 0;
  int          owed_count     = 0;

  assign mismatches = mismatch_count;
  assign pending    = owed_count;

  // out-of-range dimensions behave as the nearest legal one
  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    if (v < 2) return 2;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // mean of four samples given as two pair sums, truncated
  function automatic logic [SAMPLE_W-1:0] average4(input logic [LANE_W-1:0] a,
                                                   input logic [LANE_W-1:0] b);
    logic [LANE_W:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[LANE_W:2];
  endfunction

  always @(posedge clk) begin : track
    int                  w_eff;
    int                  h_eff;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [SLOT_W-1:0]   slot;
    pair_sum_t           sums;
    pair_sum_t           upper;
    half_pixel_t         px;
    half_pixel_t         want;

    if (!rst_n) begin
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      col_q      = '0;
      row_q      = '0;
      held_red   = '0;
      held_green = '0;
      held_blue  = '0;
      expected_pixels.delete();
    end else begin
      // register writes, indexes beyond the list are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  = cfg_data;
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end

      // source word: hold, store pair sums, or average a finished block
      if (in_tvalid && in_tready) begin
        red   = in_tdata[SAMPLE_W-1:0];
        green = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
        blue  = in_tdata[PIX_W-1:2*SAMPLE_W];
        w_eff = clamp_dim(width_reg, MAX_WIDTH);
        h_eff = clamp_dim(height_reg, MAX_HEIGHT);
        if (int'(col_q) < (w_eff & ~1) && int'(row_q) < (h_eff & ~1)) begin
          if (!col_q[0]) begin
            held_red   = red;
            held_green = green;
            held_blue  = blue;
          end else begin
            slot       = SLOT_W'(col_q >> 1);
            sums.red   = {1'b0, held_red} + {1'b0, red};
            sums.green = {1'b0, held_green} + {1'b0, green};
            sums.blue  = {1'b0, held_blue} + {1'b0, blue};
            if (!row_q[0]) begin
              even_sums[slot] = sums;
            end else begin
              upper        = even_sums[slot];
              px.red       = average4(upper.red, sums.red);
              px.green     = average4(upper.green, sums.green);
              px.blue      = average4(upper.blue, sums.blue);
              px.row_end   = (int'(col_q) >> 1) == (w_eff >> 1) - 1;
              px.frame_end = px.row_end && ((int'(row_q) >> 1) == (h_eff >> 1) - 1);
              expected_pixels.push_back(px);
            end
          end
        end
        // counters wrap at the row and frame end, also after a shrink
        if (int'(col_q) + 1 >= w_eff) begin
          col_q = '0;
          row_q = (int'(row_q) + 1 >= h_eff) ? '0 : row_q + 1'b1;
        end else begin
          col_q = col_q + 1'b1;
        end
      end

      // result word against the oldest owed pixel
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("result word with no half pixel owed");
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_tdata[SAMPLE_W-1:0] !== want.blue) begin
            $error("out_blue: expected %0d, got %0d", want.blue,
                   out_tdata[SAMPLE_W-1:0]);
            mismatch_count++;
          end
          if (out_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.green) begin
            $error("out_green: expected %0d, got %0d", want.green,
                   out_tdata[2*SAMPLE_W-1:SAMPLE_W]);
            mismatch_count++;
          end
          if (out_tdata[PIX_W-1:2*SAMPLE_W] !== want.red) begin
            $error("out_red: expected %0d, got %0d", want.red,
                   out_tdata[PIX_W-1:2*SAMPLE_W]);
            mismatch_count++;
          end
          if (out_tlast !== want.row_end) begin
            $error("row_end: expected %0d, got %0d", want.row_end, out_tlast);
            mismatch_count++;
          end
          if (out_tuser !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_tuser);
            mismatch_count++;
          end
        end
      end
    end
    owed_count = expected_pixels.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for rgb_half_downscale_bgr_core
// Streams raster RGB frames into the core under several frame sizes, with
// random gaps on the source side and random stalls on the result side,
// while half_pixel_checker predicts and compares the BGR output. A short
// directed opening covers full-scale and truncating blocks, ignored register
// indexes and shrinking the frame in the middle; then random frames follow,
// mostly small, plus short partial frames at the largest and clamped sizes.
// ----------------------------------------------------------------------------
module testbench;
  import rhd_pkg::*;

  // indexes past the register list, written to see them ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam int SMALL_PIXELS = 1800;
  localparam int CALM_PIXELS  = 1450;
  localparam int BIG_PIXELS   = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 4;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [PIX_W-1:0]     in_tdata   = '0;   // in_red, in_green, in_blue
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [PIX_W-1:0]     out_tdata;         // out_blue, out_green, out_red
  logic                 out_tlast;         // row_end
  logic                 out_tuser;         // frame_end
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [DIM_W-1:0]     cfg_data   = '0;

  int mismatches;
  int pending;

  // stimulus state: register values written and the core's frame position
  bit               calm        = 1'b0;
  bit               hold_req    = 1'b0;
  logic [DIM_W-1:0] width_set   = IMAGE_WIDTH_RST;
  logic [DIM_W-1:0] height_set  = IMAGE_HEIGHT_RST;
  int               pos_col     = 0;
  int               pos_row     = 0;
  int               pixels_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_half_downscale_bgr_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  half_pixel_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // one source word, with an optional gap in front
  task automatic send_pixel(input logic [SAMPLE_W-1:0] red,
                            input logic [SAMPLE_W-1:0] green,
                            input logic [SAMPLE_W-1:0] blue);
    int w_eff;
    int h_eff;
    if (!calm && $urandom_range(4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    in_tdata  <= {blue, green, red};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    // follow the frame position so frames can be finished cleanly
    w_eff = (width_set < 2) ? 2 : (width_set > MAX_WIDTH) ? MAX_WIDTH : int'(width_set);
    h_eff = (height_set < 2) ? 2 : (height_set > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_set);
    if (pos_col + 1 >= w_eff) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= h_eff) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  task automatic send_random_pixel;
    send_pixel(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
  endtask

  // random words up to the top-left of the next frame
  task automatic finish_frame;
    while (pos_col != 0 || pos_row != 0) send_random_pixel();
  endtask

  task automatic send_frames(input int count);
    repeat (count) begin
      send_random_pixel();
      finish_frame();
    end
  endtask

  // stop the source and wait until every owed pixel is out
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [DIM_W-1:0]     value);
    cfg_index <= index;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (index == REG_IMAGE_WIDTH) width_set = value;
    else if (index == REG_IMAGE_HEIGHT) height_set = value;
  endtask

  // result side: stall bursts, long stretches of ready, one long hold-off
  initial begin
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(7, 1)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(40, 1)) @(posedge clk);
    end
  end

  // main sequence
  initial begin
    logic [DIM_W-1:0] new_w;
    logic [DIM_W-1:0] new_h;
    bit               big;
    int               phase;
    int               small_count;
    int               mark;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest frame: full scale, zero, truncating blocks; spare indexes
    write_reg(REG_IMAGE_WIDTH, DIM_W'(2));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(2));
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, DIM_W'(5));
    repeat (4) send_pixel(8'hff, 8'hff, 8'hff);
    repeat (4) send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'h00, 8'h01);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'hff, 8'h01, 8'h00);
    send_pixel(8'hfe, 8'h01, 8'h01);
    drain();

    // shrink the width while the column is past the new end
    write_reg(REG_IMAGE_WIDTH, DIM_W'(4));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(4));
    repeat (7) send_random_pixel();
    drain();
    write_reg(REG_IMAGE_WIDTH, DIM_W'(2));
    repeat (3) send_random_pixel();
    drain();
    // shrink the height while the row is past the new end
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(2));
    finish_frame();

    // random frames; the largest and clamped sizes get a partial frame each
    hold_req    = 1'b1;
    phase       = 0;
    small_count = 0;
    while (small_count < SMALL_PIXELS) begin
      drain();
      big = 1'b1;
      case (phase)
        1: begin
          new_w = DIM_W'(MAX_WIDTH);
          new_h = DIM_W'(1);
        end
        3: begin
          new_w = DIM_W'(1);
          new_h = '1;
        end
        5: begin
          new_w = '1;
          new_h = DIM_W'(2);
        end
        default: begin
          big   = 1'b0;
          new_w = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(1, 0))
                                           : DIM_W'($urandom_range(24, 2));
          new_h = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(1, 0))
                                           : DIM_W'($urandom_range(8, 2));
        end
      endcase
      write_reg(REG_IMAGE_WIDTH, new_w);
      write_reg(REG_IMAGE_HEIGHT, new_h);
      if ($urandom_range(7) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, DIM_W'($urandom));
      mark = pixels_sent;
      if (big) begin
        // start a large frame, then shrink to the smallest one to leave it
        repeat (BIG_PIXELS) send_random_pixel();
        drain();
        write_reg(REG_IMAGE_WIDTH, DIM_W'(2));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(2));
        finish_frame();
      end else begin
        send_frames($urandom_range(3, 1));
        small_count += pixels_sent - mark;
      end
      if (small_count >= CALM_PIXELS) calm = 1'b1;
      phase++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ rgb_half_downscale_bgr_core.f @@
hw/rtl/rhd_pkg.sv
hw/rtl/rhd_ram.sv
hw/rtl/rgb_half_downscale_bgr_core.sv
test/half_pixel_checker.sv
test/testbench.sv
